// ===== src/sskd_pkg.sv =====
package sskd_pkg;

  localparam logic [7:0] SCAN_EXT_PREFIX = 8'hE0;
  localparam logic [7:0] SCAN_BRK_PREFIX = 8'hF0;
  localparam logic [6:0] MAX_CODE        = 7'd83;

  // plain (no prefix) modifier keys
  localparam logic [6:0] KEY_LCTRL  = 7'd29;
  localparam logic [6:0] KEY_LALT   = 7'd56;
  localparam logic [6:0] KEY_LSHIFT = 7'd42;
  localparam logic [6:0] KEY_RSHIFT = 7'd54;
  localparam logic [6:0] KEY_CAPS   = 7'd58;

  // extended modifier keys
  localparam logic [6:0] KEY_RCTRL = 7'd29;
  localparam logic [6:0] KEY_RALT  = 7'd56;
  localparam logic [6:0] KEY_LGUI  = 7'd91;
  localparam logic [6:0] KEY_RGUI  = 7'd92;

  // extended special keys
  localparam logic [6:0] KEY_INSERT = 7'd82;
  localparam logic [6:0] KEY_PGUP   = 7'd73;
  localparam logic [6:0] KEY_PGDN   = 7'd81;
  localparam logic [6:0] KEY_UP     = 7'd72;
  localparam logic [6:0] KEY_LEFT   = 7'd75;
  localparam logic [6:0] KEY_DOWN   = 7'd80;
  localparam logic [6:0] KEY_RIGHT  = 7'd77;

  // modifier bit positions
  localparam int MOD_LCTRL  = 0;
  localparam int MOD_LALT   = 1;
  localparam int MOD_LSHIFT = 2;
  localparam int MOD_RSHIFT = 3;
  localparam int MOD_RCTRL  = 4;
  localparam int MOD_RALT   = 5;
  localparam int MOD_LGUI   = 6;
  localparam int MOD_RGUI   = 7;

  // special bit positions
  localparam int SPC_INSERT = 0;
  localparam int SPC_PGUP   = 1;
  localparam int SPC_PGDN   = 2;
  localparam int SPC_UP     = 3;
  localparam int SPC_LEFT   = 4;
  localparam int SPC_DOWN   = 5;
  localparam int SPC_RIGHT  = 6;

  typedef struct packed {
    logic       ext;
    logic       brk;
    logic [7:0] mods;
    logic [6:0] specs;
    logic       latch;
  } key_state_t;

  typedef struct packed {
    logic [6:0] character;
    logic [7:0] mods;
    logic [6:0] specs;
  } result_t;

  // keypad block and other entries common to both layers
  function automatic logic [6:0] common_char(input logic [6:0] code);
    logic [6:0] ch;
    begin
      ch = 7'd0;
      case (code)
        7'd1:  ch = 7'd27;
        7'd14: ch = 7'd8;
        7'd15: ch = 7'd9;
        7'd28: ch = 7'd10;
        7'd41: ch = 7'd92;
        7'd55: ch = 7'd42;
        7'd57: ch = 7'd32;
        7'd71: ch = 7'd55;
        7'd72: ch = 7'd56;
        7'd73: ch = 7'd57;
        7'd74: ch = 7'd45;
        7'd75: ch = 7'd52;
        7'd76: ch = 7'd53;
        7'd77: ch = 7'd54;
        7'd78: ch = 7'd43;
        7'd79: ch = 7'd49;
        7'd80: ch = 7'd50;
        7'd81: ch = 7'd51;
        7'd82: ch = 7'd48;
        7'd83: ch = 7'd127;
        default: ch = 7'd0;
      endcase
      return ch;
    end
  endfunction

  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] ch;
    begin
      ch = common_char(code);
      case (code)
        7'd2:  ch = 7'd38;
        7'd3:  ch = 7'd126;
        7'd4:  ch = 7'd34;
        7'd5:  ch = 7'd39;
        7'd6:  ch = 7'd40;
        7'd7:  ch = 7'd45;
        7'd8:  ch = 7'd96;
        7'd9:  ch = 7'd95;
        7'd10: ch = 7'd94;
        7'd11: ch = 7'd64;
        7'd12: ch = 7'd41;
        7'd13: ch = 7'd61;
        7'd16: ch = 7'd97;
        7'd17: ch = 7'd122;
        7'd18: ch = 7'd101;
        7'd19: ch = 7'd114;
        7'd20: ch = 7'd116;
        7'd21: ch = 7'd121;
        7'd22: ch = 7'd117;
        7'd23: ch = 7'd105;
        7'd24: ch = 7'd111;
        7'd25: ch = 7'd112;
        7'd26: ch = 7'd94;
        7'd27: ch = 7'd36;
        7'd30: ch = 7'd113;
        7'd31: ch = 7'd115;
        7'd32: ch = 7'd100;
        7'd33: ch = 7'd102;
        7'd34: ch = 7'd103;
        7'd35: ch = 7'd104;
        7'd36: ch = 7'd106;
        7'd37: ch = 7'd107;
        7'd38: ch = 7'd108;
        7'd39: ch = 7'd109;
        7'd40: ch = 7'd37;
        7'd43: ch = 7'd42;
        7'd44: ch = 7'd119;
        7'd45: ch = 7'd120;
        7'd46: ch = 7'd99;
        7'd47: ch = 7'd118;
        7'd48: ch = 7'd98;
        7'd49: ch = 7'd110;
        7'd50: ch = 7'd44;
        7'd51: ch = 7'd59;
        7'd52: ch = 7'd58;
        7'd53: ch = 7'd33;
        default: ch = ch;
      endcase
      return ch;
    end
  endfunction

  function automatic logic [6:0] shifted_char(input logic [6:0] code);
    logic [6:0] ch;
    begin
      ch = common_char(code);
      case (code)
        7'd2:  ch = 7'd49;
        7'd3:  ch = 7'd50;
        7'd4:  ch = 7'd51;
        7'd5:  ch = 7'd52;
        7'd6:  ch = 7'd53;
        7'd7:  ch = 7'd54;
        7'd8:  ch = 7'd55;
        7'd9:  ch = 7'd56;
        7'd10: ch = 7'd57;
        7'd11: ch = 7'd48;
        7'd12: ch = 7'd45;
        7'd13: ch = 7'd43;
        7'd16: ch = 7'd65;
        7'd17: ch = 7'd90;
        7'd18: ch = 7'd69;
        7'd19: ch = 7'd82;
        7'd20: ch = 7'd84;
        7'd21: ch = 7'd89;
        7'd22: ch = 7'd85;
        7'd23: ch = 7'd73;
        7'd24: ch = 7'd79;
        7'd25: ch = 7'd80;
        7'd26: ch = 7'd91;
        7'd27: ch = 7'd93;
        7'd30: ch = 7'd81;
        7'd31: ch = 7'd83;
        7'd32: ch = 7'd68;
        7'd33: ch = 7'd70;
        7'd34: ch = 7'd71;
        7'd35: ch = 7'd72;
        7'd36: ch = 7'd74;
        7'd37: ch = 7'd75;
        7'd38: ch = 7'd76;
        7'd39: ch = 7'd77;
        7'd40: ch = 7'd60;
        7'd43: ch = 7'd62;
        7'd44: ch = 7'd87;
        7'd45: ch = 7'd88;
        7'd46: ch = 7'd67;
        7'd47: ch = 7'd86;
        7'd48: ch = 7'd66;
        7'd49: ch = 7'd78;
        7'd50: ch = 7'd63;
        7'd51: ch = 7'd46;
        7'd52: ch = 7'd47;
        7'd53: ch = 7'd124;
        default: ch = ch;
      endcase
      return ch;
    end
  endfunction

endpackage

// ===== src/sskd_decode.sv =====
module sskd_decode (
  input  logic               enable,
  input  logic [7:0]         scan_byte,
  input  sskd_pkg::key_state_t state,
  output sskd_pkg::key_state_t state_next,
  output logic               emit,
  output sskd_pkg::result_t  result
);
  import sskd_pkg::*;

  logic       down;
  logic [6:0] code;
  logic       tracked;
  logic       shifted;
  logic [6:0] ch;

  assign down = ~scan_byte[7];
  assign code = scan_byte[6:0];

  always_comb begin
    state_next = state;
    tracked    = 1'b0;
    emit       = 1'b0;
    ch         = 7'd0;
    shifted    = state.mods[MOD_LSHIFT] ^ state.mods[MOD_RSHIFT] ^ state.latch;
    if (!enable) begin
      state_next = state;
    end else if (scan_byte == SCAN_EXT_PREFIX) begin
      state_next.ext = 1'b1;
    end else if (scan_byte == SCAN_BRK_PREFIX) begin
      state_next.brk = 1'b1;
    end else begin
      if (state.ext) begin
        tracked = 1'b1;
        case (code)
          KEY_RCTRL:  state_next.mods[MOD_RCTRL]   = down;
          KEY_RALT:   state_next.mods[MOD_RALT]    = down;
          KEY_LGUI:   state_next.mods[MOD_LGUI]    = down;
          KEY_RGUI:   state_next.mods[MOD_RGUI]    = down;
          KEY_INSERT: state_next.specs[SPC_INSERT] = down;
          KEY_PGUP:   state_next.specs[SPC_PGUP]   = down;
          KEY_PGDN:   state_next.specs[SPC_PGDN]   = down;
          KEY_UP:     state_next.specs[SPC_UP]     = down;
          KEY_LEFT:   state_next.specs[SPC_LEFT]   = down;
          KEY_DOWN:   state_next.specs[SPC_DOWN]   = down;
          KEY_RIGHT:  state_next.specs[SPC_RIGHT]  = down;
          default:    tracked = 1'b0;
        endcase
      end else if (!state.brk) begin
        tracked = 1'b1;
        case (code)
          KEY_LCTRL:  state_next.mods[MOD_LCTRL]  = down;
          KEY_LALT:   state_next.mods[MOD_LALT]   = down;
          KEY_LSHIFT: state_next.mods[MOD_LSHIFT] = down;
          KEY_RSHIFT: state_next.mods[MOD_RSHIFT] = down;
          KEY_CAPS: begin
            tracked = 1'b0;
            if (!down) begin
              state_next.latch = ~state.latch;
            end
          end
          default: tracked = 1'b0;
        endcase
      end

      if (tracked) begin
        emit = down;
      end else if (down && code <= MAX_CODE) begin
        // shift state comes from before this byte; shift keys and a caps release move it only for later bytes
        ch   = shifted ? shifted_char(code) : plain_char(code);
        emit = (ch != 7'd0);
      end

      state_next.ext = 1'b0;
      state_next.brk = 1'b0;
    end
  end

  assign result.character = ch;
  assign result.mods      = state_next.mods;
  assign result.specs     = state_next.specs;

endmodule

// ===== src/sskd_out_reg.sv =====
module sskd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sskd_pkg::result_t load_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output sskd_pkg::result_t out_data
);
  import sskd_pkg::*;

  assign free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== src/scancode_set1_key_decoder_core.sv =====
// Set 1 keyboard scan byte decoder with AZERTY mapping. One scan byte is taken
// per request on the input channel; it sits in the input register and is
// decoded and mapped there, and its result is loaded into the result register,
// from which it is offered; a new byte can be taken every cycle while in_stall
// is low. A byte that
// gives a character or a modifier/special-key press produces one result
// request carrying the character (0 for modifier and special-key presses)
// plus the held modifier and special flags; prefixes, releases and unmapped
// keys produce none. Throughput is bounded only by the single result
// register: while it holds an untaken result, a byte that would produce one
// waits in the input register. Clearing cfg_wr_data (high_level_enable)
// makes the block swallow bytes without decoding them; write it only while
// the block is idle.
module scancode_set1_key_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] character,
  output logic [7:0] modifier_bits,
  output logic [6:0] special_bits
);
  import sskd_pkg::*;

  logic       high_level_enable;
  logic       byte_valid;
  logic [7:0] byte_reg;
  key_state_t state;
  key_state_t state_next;
  logic       emit;
  result_t    result;
  result_t    out_data;
  logic       out_free;
  logic       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_level_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      high_level_enable <= cfg_wr_data;
    end
  end

  // byte leaves the input register unless its result has nowhere to go
  assign advance  = byte_valid & (~emit | out_free);
  assign in_stall = byte_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_reg <= scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  sskd_decode u_decode (
    .enable     (high_level_enable),
    .scan_byte  (byte_reg),
    .state      (state),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  sskd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance & emit),
    .load_data (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign character     = out_data.character;
  assign modifier_bits = out_data.mods;
  assign special_bits  = out_data.specs;

endmodule

// ===== verif/key_decode_checker.sv =====
module key_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] scan_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [6:0] character,
  input  logic [7:0] modifier_bits,
  input  logic [6:0] special_bits,
  output int         mismatches,
  output int         results_owed
);
  import sskd_pkg::*;

  localparam logic [6:0] LOWER_KEYMAP [0:83] = '{
    0, 27, 38, 126, 34, 39, 40, 45, 96, 95, 94, 64, 41, 61, 8, 9,
    97, 122, 101, 114, 116, 121, 117, 105, 111, 112, 94, 36, 10, 0,
    113, 115, 100, 102, 103, 104, 106, 107, 108, 109, 37, 92, 0, 42,
    119, 120, 99, 118, 98, 110, 44, 59, 58, 33, 0, 42, 0, 32,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    55, 56, 57, 45, 52, 53, 54, 43, 49, 50, 51, 48, 127
  };

  localparam logic [6:0] UPPER_KEYMAP [0:83] = '{
    0, 27, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 43, 8, 9,
    65, 90, 69, 82, 84, 89, 85, 73, 79, 80, 91, 93, 10, 0,
    81, 83, 68, 70, 71, 72, 74, 75, 76, 77, 60, 92, 0, 62,
    87, 88, 67, 86, 66, 78, 63, 46, 47, 124, 0, 42, 0, 32,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    55, 56, 57, 45, 52, 53, 54, 43, 49, 50, 51, 48, 127
  };

  logic       decode_on;
  logic       ext_seen;
  logic       brk_seen;
  logic [7:0] mods_held;
  logic [6:0] specs_held;
  logic       caps_latch;
  result_t    keys_owed [$];

  // Advances the shadow keyboard state by one byte; returns 1 when a result is due.
  function automatic bit decode_scan_byte(input logic [7:0] value, output result_t res);
    logic [6:0] code;
    logic       down;
    bit         held_key;
    bit         emit;
    logic [6:0] ch;
    res      = '0;
    held_key = 1'b0;
    emit     = 1'b0;
    ch       = '0;
    if (!decode_on) return 1'b0;
    if (value == SCAN_EXT_PREFIX) begin
      ext_seen = 1'b1;
      return 1'b0;
    end
    if (value == SCAN_BRK_PREFIX) begin
      brk_seen = 1'b1;
      return 1'b0;
    end
    down = ~value[7];
    code = value[6:0];
    if (ext_seen) begin
      held_key = 1'b1;
      case (code)
        KEY_RCTRL:  mods_held[MOD_RCTRL]   = down;
        KEY_RALT:   mods_held[MOD_RALT]    = down;
        KEY_LGUI:   mods_held[MOD_LGUI]    = down;
        KEY_RGUI:   mods_held[MOD_RGUI]    = down;
        KEY_INSERT: specs_held[SPC_INSERT] = down;
        KEY_PGUP:   specs_held[SPC_PGUP]   = down;
        KEY_PGDN:   specs_held[SPC_PGDN]   = down;
        KEY_UP:     specs_held[SPC_UP]     = down;
        KEY_LEFT:   specs_held[SPC_LEFT]   = down;
        KEY_DOWN:   specs_held[SPC_DOWN]   = down;
        KEY_RIGHT:  specs_held[SPC_RIGHT]  = down;
        default:    held_key = 1'b0;
      endcase
    end else if (!brk_seen) begin
      held_key = 1'b1;
      case (code)
        KEY_LCTRL:  mods_held[MOD_LCTRL]  = down;
        KEY_LALT:   mods_held[MOD_LALT]   = down;
        KEY_LSHIFT: mods_held[MOD_LSHIFT] = down;
        KEY_RSHIFT: mods_held[MOD_RSHIFT] = down;
        default: begin
          held_key = 1'b0;
          if (code == KEY_CAPS && !down) caps_latch = ~caps_latch;
        end
      endcase
    end
    if (held_key) begin
      emit = down;
    end else if (down && code <= MAX_CODE) begin
      if (mods_held[MOD_LSHIFT] ^ mods_held[MOD_RSHIFT] ^ caps_latch) ch = UPPER_KEYMAP[code];
      else ch = LOWER_KEYMAP[code];
      emit = (ch != '0);
    end
    ext_seen = 1'b0;
    brk_seen = 1'b0;
    res.character = ch;
    res.mods      = mods_held;
    res.specs     = specs_held;
    return emit;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      bad;
    bad = 0;
    if (rst) begin
      decode_on  = 1'b1;
      ext_seen   = 1'b0;
      brk_seen   = 1'b0;
      mods_held  = '0;
      specs_held = '0;
      caps_latch = 1'b0;
      keys_owed.delete();
      mismatches <= 0;
    end else begin
      if (cfg_wr_en) decode_on = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (decode_scan_byte(scan_byte, want)) keys_owed.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (keys_owed.size() == 0) begin
          $display("%0t: unexpected result: character %0d mods %h specials %h",
                   $time, character, modifier_bits, special_bits);
          bad++;
        end else begin
          want = keys_owed.pop_front();
          if (character !== want.character) begin
            $display("%0t: character mismatch: expected %0d, got %0d",
                     $time, want.character, character);
            bad++;
          end
          if (modifier_bits !== want.mods) begin
            $display("%0t: modifier_bits mismatch: expected %h, got %h",
                     $time, want.mods, modifier_bits);
            bad++;
          end
          if (special_bits !== want.specs) begin
            $display("%0t: special_bits mismatch: expected %h, got %h",
                     $time, want.specs, special_bits);
            bad++;
          end
        end
      end
      mismatches <= mismatches + bad;
    end
    results_owed <= keys_owed.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import sskd_pkg::*;

  typedef enum int {
    TRAFFIC_FULL,
    TRAFFIC_SRC_GAPS,
    TRAFFIC_SINK_STALLS,
    TRAFFIC_BOTH,
    TRAFFIC_HOLD
  } traffic_t;

  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 320;

  localparam logic [6:0] PLAIN_MODS [0:3] = '{KEY_LCTRL, KEY_LALT, KEY_LSHIFT, KEY_RSHIFT};
  localparam logic [6:0] EXT_KEYS [0:10] = '{
    KEY_RCTRL, KEY_RALT, KEY_LGUI, KEY_RGUI, KEY_INSERT, KEY_PGUP,
    KEY_PGDN, KEY_UP, KEY_LEFT, KEY_DOWN, KEY_RIGHT
  };

  // edges of the tables, several prefix combinations, shift/caps interplay
  localparam logic [7:0] OPENING_BYTES [0:31] = '{
    8'h00, 8'h01, 8'h10, {1'b0, MAX_CODE}, 8'h7F, 8'hFF,
    {1'b0, KEY_LSHIFT}, 8'h10, {1'b1, KEY_LSHIFT},
    {1'b0, KEY_CAPS}, {1'b1, KEY_CAPS}, 8'h10, {1'b0, KEY_RSHIFT}, 8'h10,
    {1'b1, KEY_RSHIFT}, {1'b1, KEY_CAPS},
    SCAN_EXT_PREFIX, {1'b0, KEY_RCTRL}, SCAN_EXT_PREFIX, {1'b0, KEY_UP},
    SCAN_EXT_PREFIX, 8'h10, SCAN_BRK_PREFIX, {1'b0, KEY_LCTRL},
    SCAN_EXT_PREFIX, SCAN_BRK_PREFIX, {1'b0, KEY_RALT},
    SCAN_EXT_PREFIX, SCAN_EXT_PREFIX, {1'b1, KEY_UP},
    SCAN_BRK_PREFIX, {1'b1, KEY_CAPS}
  };

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] scan_byte;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] character;
  logic [7:0] modifier_bits;
  logic [6:0] special_bits;
  int         mismatches;
  int         results_owed;
  int         sent_count;
  traffic_t   traffic;

  scancode_set1_key_decoder_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .scan_byte    (scan_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .character    (character),
    .modifier_bits(modifier_bits),
    .special_bits (special_bits)
  );

  key_decode_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .scan_byte    (scan_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .character    (character),
    .modifier_bits(modifier_bits),
    .special_bits (special_bits),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls per traffic mode, one long hold-off to back up the pipe.
  initial begin
    int hold_left;
    bit held_once;
    int stall_pct;
    hold_left = 0;
    held_once = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      stall_pct = (traffic == TRAFFIC_SINK_STALLS) ? 45 : (traffic == TRAFFIC_BOTH) ? 11 : 0;
      if (traffic == TRAFFIC_HOLD && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value);
    int gap_pct;
    gap_pct = (traffic == TRAFFIC_SRC_GAPS) ? 45 : (traffic == TRAFFIC_BOTH) ? 11 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid  <= 1'b0;
      scan_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    scan_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Wait until every owed result is out, then let bytes that give none drain as well.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One keyboard action: mostly realistic press/release sequences, some noise.
  task automatic send_gesture();
    int         pick;
    logic [6:0] code;
    logic       lift;
    pick = $urandom_range(99);
    code = 7'($urandom_range(83, 1));
    lift = 1'($urandom_range(1));
    if (pick < 40) begin
      send_byte({1'b0, code});
      send_byte({1'b1, code});
    end else if (pick < 50) begin
      send_byte({1'b0, code});
    end else if (pick < 62) begin
      send_byte({lift, PLAIN_MODS[$urandom_range(3)]});
    end else if (pick < 74) begin
      send_byte(SCAN_EXT_PREFIX);
      send_byte({lift, EXT_KEYS[$urandom_range(10)]});
    end else if (pick < 80) begin
      send_byte({1'b0, KEY_CAPS});
      send_byte({1'b1, KEY_CAPS});
    end else if (pick < 86) begin
      send_byte(SCAN_BRK_PREFIX);
      send_byte({lift, code});
    end else if (pick < 90) begin
      send_byte(SCAN_EXT_PREFIX);
      send_byte({lift, code});
    end else if (pick < 93) begin
      send_byte(SCAN_EXT_PREFIX);
      send_byte(SCAN_BRK_PREFIX);
      send_byte({lift, EXT_KEYS[$urandom_range(10)]});
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input traffic_t mode, input int count);
    int start;
    traffic <= mode;
    start = sent_count;
    while (sent_count - start < count) send_gesture();
  endtask

  initial begin
    sent_count  = 0;
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b1;
    in_valid    <= 1'b0;
    scan_byte   <= 8'h00;
    traffic     <= TRAFFIC_FULL;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_enable(1'b1);
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

    // decoding off: everything is swallowed, prefixes included
    write_enable(1'b0);
    send_byte(SCAN_EXT_PREFIX);
    send_byte({1'b0, KEY_LSHIFT});
    send_byte({1'b1, KEY_CAPS});
    repeat (30) send_byte(8'($urandom_range(255)));
    write_enable(1'b1);

    run_phase(TRAFFIC_FULL, ITEMS_PER_PHASE);
    run_phase(TRAFFIC_SRC_GAPS, ITEMS_PER_PHASE);
    run_phase(TRAFFIC_SINK_STALLS, ITEMS_PER_PHASE);
    run_phase(TRAFFIC_BOTH, ITEMS_PER_PHASE);

    write_enable(1'b0);
    repeat (40) send_gesture();
    write_enable(1'b1);

    // letter presses keep the request stream busy while the result side holds off
    traffic <= TRAFFIC_HOLD;
    repeat (60) send_byte({1'b0, 7'($urandom_range(25, 16))});
    run_phase(TRAFFIC_SINK_STALLS, ITEMS_PER_PHASE - 60);

    settle();
    if (mismatches == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (results_owed != 0) $display("%0d expected results never arrived", results_owed);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sskd_pkg.sv
src/sskd_decode.sv
src/sskd_out_reg.sv
src/scancode_set1_key_decoder_core.sv
verif/key_decode_checker.sv
verif/tb_top.sv
